### design/sbda_pkg.sv
// Shared constants and helpers for the signed binary to decimal text converter.
package sbda_pkg;

    localparam int DIGIT_COUNT_DEF = 10;
    // Positions beyond ten can never hold a nonzero digit of a 32-bit magnitude.
    localparam int DIGIT_MAX       = 10;
    localparam int NUM_W           = 32;
    localparam int MAG_W           = 32;
    // Wide enough for eight times one billion.
    localparam int CMP_W           = 34;
    localparam int CHAR_W          = 6;
    localparam int TDATA_OUT_W     = 8;

    localparam logic [CHAR_W-1:0] CODE_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CODE_NINE  = 6'd57;

    // Ten to the power n, evaluated at elaboration only.
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < n; i++) begin
            r = r * 64'd10;
        end
        return r;
    endfunction

endpackage

### design/signed_binary_to_decimal_ascii_core.sv
// Signed 32-bit integer to decimal ASCII text converter, one character per output request.
//
// Each input request carries one two's complement number; the output channel returns its
// decimal text one character per request: a minus sign for negative values, then the digits
// with leading zeros suppressed (a lone '0' for zero), the final character flagged by tlast.
// The digits come out of a pipeline of 2 + 2*P stages (P = DIGIT_COUNT clamped to 1..10),
// each digit stage doing two restoring compare-subtract steps, and the last stage feeds the
// character serializer. The serializer sends one character per cycle while m_tready is high,
// so a number occupies the output for its text of 1 to 11 characters, and that length sets
// the sustained input rate; a new number can enter every cycle while the pipeline has room.
// With DIGIT_COUNT below ten, larger magnitudes saturate to all nines.
module signed_binary_to_decimal_ascii_core #(
    parameter int DIGIT_COUNT = sbda_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic signed [sbda_pkg::NUM_W-1:0]     s_tdata,   // [31:0] number
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic        [sbda_pkg::TDATA_OUT_W-1:0] m_tdata, // [5:0] char_code, [7:6] zero
    output logic                                  m_tlast    // last_char
);
    import sbda_pkg::*;

    localparam int EFF   = (DIGIT_COUNT < 1) ? 1 :
                           ((DIGIT_COUNT > DIGIT_MAX) ? DIGIT_MAX : DIGIT_COUNT);
    localparam bit CAP_EN = (DIGIT_COUNT < DIGIT_MAX);
    localparam logic [MAG_W-1:0] CAP = MAG_W'(pow10(EFF) - 64'd1);
    localparam int NSTG  = 2 + 2 * EFF;
    localparam int PTR_W = (EFF > 1) ? $clog2(EFF) : 1;

    typedef struct packed {
        logic                 neg;
        logic [MAG_W-1:0]     mag;
        logic [EFF-1:0][3:0]  digs;   // index 0 is the most significant position
    } stg_t;

    stg_t             stg_reg  [NSTG];
    stg_t             stg_next [NSTG];
    logic [NSTG-1:0]  vld_reg;
    logic [NSTG-1:0]  vin;
    logic [NSTG:0]    rdy;

    logic                 busy_reg, busy_next;
    logic                 minus_reg, minus_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [EFF-1:0][3:0]  digs_reg, digs_next;
    logic [PTR_W-1:0]     first_idx;
    logic                 load;
    logic                 out_done;
    logic [CHAR_W-1:0]    char_code;

    assign s_tready = rdy[0];

    for (genvar j = 0; j < NSTG; j++) begin : g_stg
        // A stage takes a new request when it is empty or its contents move on.
        assign rdy[j] = !vld_reg[j] || rdy[j+1];

        if (j == 0) begin : g_in
            assign vin[j] = s_tvalid;
            always_comb begin
                stg_next[j].neg  = s_tdata[NUM_W-1];
                stg_next[j].mag  = s_tdata[NUM_W-1] ? (~s_tdata[NUM_W-1:0] + MAG_W'(1))
                                                     : s_tdata[NUM_W-1:0];
                stg_next[j].digs = '0;
            end
        end else if (j == 1) begin : g_cap
            assign vin[j] = vld_reg[j-1];
            always_comb begin
                stg_next[j] = stg_reg[j-1];
                if (CAP_EN && (stg_reg[j-1].mag > CAP)) begin
                    stg_next[j].mag = CAP;
                end
            end
        end else begin : g_dig
            localparam int D  = (j - 2) / 2;
            localparam int K1 = (((j - 2) % 2) == 0) ? 3 : 1;
            localparam int K0 = K1 - 1;
            localparam logic [CMP_W-1:0] W1 = CMP_W'(pow10(EFF - 1 - D) << K1);
            localparam logic [CMP_W-1:0] W0 = CMP_W'(pow10(EFF - 1 - D) << K0);
            logic [CMP_W-1:0] m1;
            logic [CMP_W-1:0] m0;
            logic             b1;
            logic             b0;
            assign vin[j] = vld_reg[j-1];
            always_comb begin
                m1 = {{(CMP_W-MAG_W){1'b0}}, stg_reg[j-1].mag};
                b1 = (m1 >= W1);
                m0 = b1 ? (m1 - W1) : m1;
                b0 = (m0 >= W0);
                stg_next[j]            = stg_reg[j-1];
                stg_next[j].mag        = MAG_W'(b0 ? (m0 - W0) : m0);
                stg_next[j].digs[D][K1] = b1;
                stg_next[j].digs[D][K0] = b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                vld_reg[j] <= vin[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[j]) begin
                stg_reg[j] <= stg_next[j];
            end
        end
    end

    // Character serializer.
    assign m_tvalid  = busy_reg;
    assign m_tlast   = !minus_reg && (ptr_reg == PTR_W'(EFF - 1));
    assign char_code = minus_reg ? CODE_MINUS
                                 : (CODE_ZERO + {{(CHAR_W-4){1'b0}}, digs_reg[ptr_reg]});
    assign m_tdata   = {{(TDATA_OUT_W-CHAR_W){1'b0}}, char_code};

    assign out_done  = busy_reg && m_tready && m_tlast;
    assign rdy[NSTG] = !busy_reg || out_done;
    assign load      = rdy[NSTG] && vld_reg[NSTG-1];

    // First nonzero digit, or the lowest position when the value is zero.
    always_comb begin
        first_idx = PTR_W'(EFF - 1);
        for (int i = EFF - 1; i >= 0; i--) begin
            if (stg_reg[NSTG-1].digs[i] != 4'd0) begin
                first_idx = PTR_W'(i);
            end
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        minus_next = minus_reg;
        ptr_next   = ptr_reg;
        digs_next  = digs_reg;
        if (busy_reg && m_tready && !m_tlast) begin
            if (minus_reg) begin
                minus_next = 1'b0;
            end else begin
                ptr_next = ptr_reg + PTR_W'(1);
            end
        end
        if (load) begin
            busy_next  = 1'b1;
            minus_next = stg_reg[NSTG-1].neg;
            ptr_next   = first_idx;
            digs_next  = stg_reg[NSTG-1].digs;
        end else if (out_done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            minus_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            minus_reg <= minus_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg  <= ptr_next;
        digs_reg <= digs_next;
    end

endmodule

### design/sbda_checker.sv
// Port-level checks on the decimal text stream of the converter, and their binding.
module sbda_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [sbda_pkg::TDATA_OUT_W-1:0]       m_tdata,
    input logic                                   m_tlast
);
    import sbda_pkg::*;

    logic [CHAR_W-1:0] ch;
    logic              is_minus;

    assign ch       = m_tdata[CHAR_W-1:0];
    assign is_minus = (ch == CODE_MINUS);

    // A stalled request keeps its character and flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output request changed while stalled");

    // Only a minus sign or a decimal digit is ever sent.
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TDATA_OUT_W-1:CHAR_W] == '0) &&
                     (is_minus || ((ch >= CODE_ZERO) && (ch <= CODE_NINE))))
        else $error("character code out of range");

    // A minus sign opens a text and is never its end.
    a_minus_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !(m_tvalid && is_minus))
        else $error("minus sign inside a text");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && is_minus |-> !m_tlast)
        else $error("text ends with a minus sign");

    // The digit after a minus sign follows at once and is never a leading zero.
    a_no_lead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && is_minus |=> m_tvalid && !is_minus && (ch != CODE_ZERO))
        else $error("leading zero after minus sign");

endmodule

bind signed_binary_to_decimal_ascii_core sbda_checker u_sbda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
